### hw/rtl/assert_macros.svh
// Assertion macros used by the allocator controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// prop must hold at every clock edge outside reset
`define PCPA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// cond must never be true outside reset
`define PCPA_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PCPA_ASSERT(lbl, prop, msg)
`define PCPA_NEVER(lbl, cond, msg)
`endif
`endif

### hw/rtl/pcpa_pkg.sv
// Types and constants of the per-CPU page allocator.
package pcpa_pkg;

	localparam int ADDR_W     = 32;
	localparam int CPU_W      = 3;
	localparam int STS_W      = 2;
	localparam int PAGE_SHIFT = 12;
	// page number width, one bit more than a 32-bit address allows, for the rounded base
	localparam int PN_W       = ADDR_W - PAGE_SHIFT + 1;

	localparam logic [ADDR_W-1:0] BASE_RST = 32'h8000_0000;
	localparam logic [ADDR_W-1:0] TOP_RST  = 32'h8800_0000;
	localparam logic [PN_W-1:0]   FIRST_RST =
		PN_W'((33'(BASE_RST) + 33'd4095) >> PAGE_SHIFT);

	localparam logic OP_FREE  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	localparam logic REG_BASE = 1'b0;
	localparam logic REG_TOP  = 1'b1;

	localparam logic [STS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
	localparam logic [STS_W-1:0] STS_BAD   = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic pop;
	} cmd_t;

	typedef struct packed {
		logic alloc_hit;
	} sts_t;

endpackage

### hw/rtl/pcpa_ram.sv
// Generic single-port RAM with registered read data.
module pcpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32768
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                      wdata,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/pcpa_ctrl.sv
// Sequencer and result handshake of the per-CPU page allocator.
`include "assert_macros.svh"
module pcpa_ctrl
	import pcpa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   set_out;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_EXEC;
			ST_EXEC: begin
				if (!out_valid_q) state_d = sts.alloc_hit ? ST_POP : ST_IDLE;
			end
			ST_POP:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		cmd.pop     = 1'b0;
		set_out     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC: begin
				// wait for the result register to drain
				cmd.exec = !out_valid_q;
				set_out  = !out_valid_q && !sts.alloc_hit;
			end
			ST_POP: begin
				cmd.pop = 1'b1;
				set_out = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (set_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`PCPA_ASSERT(a_pop_after_exec, state_q == ST_POP |-> $past(state_q == ST_EXEC), "pop without exec")
	`PCPA_ASSERT(a_capture_to_exec, cmd.capture |=> (state_q == ST_EXEC), "capture did not start exec")
	`PCPA_ASSERT(a_result_source, $rose(out_valid_q) |-> $past(state_q != ST_IDLE), "result from idle")
	`PCPA_NEVER(a_exec_busy_out, (cmd.exec || cmd.pop) && out_valid_q, "pop with result pending")

endmodule

### hw/rtl/pcpa_dp.sv
// Datapath of the per-CPU page allocator: list heads, link memory, checks, result.
module pcpa_dp
	import pcpa_pkg::*;
#(
	parameter int NUM_CPUS  = 8,
	parameter int NUM_PAGES = 32768
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [ADDR_W-1:0] cfg_data,
	input  logic              op,
	input  logic [CPU_W-1:0]  cpu,
	input  logic [ADDR_W-1:0] page_address,
	input  cmd_t              cmd,
	output sts_t              sts,
	output logic [ADDR_W-1:0] alloc_address,
	output logic [STS_W-1:0]  status
);

	localparam int SW = $clog2(NUM_PAGES);
	localparam int TW = SW + 1;
	localparam int LW = NUM_CPUS > 1 ? $clog2(NUM_CPUS) : 1;

	logic [ADDR_W-1:0] base_q, top_q;
	logic [PN_W-1:0]   first_q;

	logic              op_q;
	logic [LW-1:0]     list_q;
	logic [ADDR_W-1:0] pa_q;

	logic [TW-1:0]     head_q [NUM_CPUS];
	logic [NUM_CPUS-1:0] nz;
	logic [LW-1:0]     low_idx, sel;
	logic [LW-1:0]     sel_q;
	logic [SW-1:0]     slot_q;
	logic [LW-1:0]     cpu_map [2**CPU_W];

	logic [PN_W-1:0]   pn, diff;
	logic              bad, is_alloc, hit;
	logic [SW-1:0]     free_slot, rd_slot;
	logic [TW-1:0]     tag_m1;

	logic              ram_we;
	logic [SW-1:0]     ram_addr;
	logic [TW-1:0]     ram_rdata;

	logic [ADDR_W-1:0] alloc_address_q;
	logic [STS_W-1:0]  status_q;

	// cpu number to list, wrapping modulo the list count
	for (genvar g = 0; g < 2**CPU_W; g++) begin : g_map
		assign cpu_map[g] = LW'(g % NUM_CPUS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= BASE_RST;
			top_q   <= TOP_RST;
			first_q <= FIRST_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE: begin
					base_q  <= cfg_data;
					first_q <= PN_W'((33'(cfg_data) + 33'd4095) >> PAGE_SHIFT);
				end
				REG_TOP:  top_q <= cfg_data;
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op;
			list_q <= cpu_map[cpu];
			pa_q   <= page_address;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_CPUS; i++) begin
			nz[i] = head_q[i] != '0;
		end
		low_idx = '0;
		for (int i = NUM_CPUS - 1; i >= 0; i--) begin
			if (nz[i]) low_idx = LW'(i);
		end
	end

	assign is_alloc  = op_q == OP_ALLOC;
	assign hit       = |nz;
	assign sel       = nz[list_q] ? list_q : low_idx;
	assign tag_m1    = head_q[sel] - TW'(1);
	assign rd_slot   = tag_m1[SW-1:0];

	assign pn        = {1'b0, pa_q[ADDR_W-1:PAGE_SHIFT]};
	assign diff      = pn - first_q;
	assign free_slot = diff[SW-1:0];
	assign bad = (|pa_q[PAGE_SHIFT-1:0]) || (pa_q < base_q) || (pa_q >= top_q)
		|| (pn < first_q) || (diff >= PN_W'(NUM_PAGES));

	assign sts.alloc_hit = is_alloc && hit;

	assign ram_we   = cmd.exec && !is_alloc && !bad;
	assign ram_addr = is_alloc ? rd_slot : free_slot;

	pcpa_ram #(
		.WIDTH(TW),
		.DEPTH(NUM_PAGES)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(head_q[list_q]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CPUS; i++) begin
				head_q[i] <= '0;
			end
		end else if (ram_we) begin
			head_q[list_q] <= TW'(free_slot) + TW'(1);
		end else if (cmd.pop) begin
			head_q[sel_q] <= ram_rdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			sel_q  <= sel;
			slot_q <= rd_slot;
			if (!is_alloc) begin
				alloc_address_q <= '0;
				status_q        <= bad ? STS_BAD : STS_OK;
			end else if (!hit) begin
				alloc_address_q <= '0;
				status_q        <= STS_EMPTY;
			end
		end else if (cmd.pop) begin
			// rebuild the address from the current base
			alloc_address_q <= {first_q[PN_W-2:0] + (PN_W-1)'(slot_q), {PAGE_SHIFT{1'b0}}};
			status_q        <= STS_OK;
		end
	end

	assign alloc_address = alloc_address_q;
	assign status        = status_q;

endmodule

### hw/rtl/per_cpu_page_free_list_allocator.sv
// Top level of the per-CPU page allocator.
// Page allocator with one LIFO free list per CPU. A free item pushes a
// 4096-aligned page lying in [base_address, top_address) and inside the
// store onto the issuing CPU's list, or returns status 2 and changes
// nothing. An allocate item pops the issuing CPU's list, else the lowest
// numbered non-empty list, else returns address 0 with status 1. Items are
// handled one at a time: a free, or an allocate that finds every list empty,
// passes through the execute state, which loads the result register; an
// allocate that finds a page then also passes through the pop state, which
// takes the registered read of the single-port link memory (NUM_PAGES
// entries), updates the list head and loads the result. The next item is
// accepted while a result waits; it stalls only when its own result would
// overwrite one not yet taken. Double frees are not detected. Configuration
// writes must be made while the block is idle.
module per_cpu_page_free_list_allocator
	import pcpa_pkg::*;
#(
	parameter int NUM_CPUS  = 8,
	parameter int NUM_PAGES = 32768
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [ADDR_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              op,
	input  logic [CPU_W-1:0]  cpu,
	input  logic [ADDR_W-1:0] page_address,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ADDR_W-1:0] alloc_address,
	output logic [STS_W-1:0]  status
);

	cmd_t cmd;
	sts_t sts;

	pcpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pcpa_dp #(
		.NUM_CPUS (NUM_CPUS),
		.NUM_PAGES(NUM_PAGES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op           (op),
		.cpu          (cpu),
		.page_address (page_address),
		.cmd          (cmd),
		.sts          (sts),
		.alloc_address(alloc_address),
		.status       (status)
	);

endmodule
